// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each use sits on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk_i outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/csq_pkg.sv =====
`timescale 1ns / 1ps

package csq_pkg;

  localparam int unsigned OpWidth    = 3;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = 6;

  typedef enum logic [OpWidth-1:0] {
    OP_START   = 3'd0,
    OP_ADVANCE = 3'd1,
    OP_INSERT  = 3'd2,
    OP_ATTACH  = 3'd3,
    OP_REMOVE  = 3'd4,
    OP_READ    = 3'd5
  } op_e;

  // Command applied to all cells of a stack in the same cycle.
  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP,
    STK_REPL
  } stk_cmd_e;

  // Command seen by one cell of a stack.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_PREV,
    CELL_TAKE_NEXT
  } cell_cmd_e;

  typedef struct packed {
    stk_cmd_e left_cmd;
    stk_cmd_e right_cmd;
  } zip_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REWIND,
    ST_PLACE
  } csq_state_e;

endpackage

// ===== sv/csq_cell.sv =====
`timescale 1ns / 1ps

module csq_cell #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  csq_pkg::cell_cmd_e    cmd_i,
  input  logic [DATA_WIDTH-1:0] prev_i,
  input  logic [DATA_WIDTH-1:0] next_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    case (cmd_i)
      csq_pkg::CELL_TAKE_PREV: data_d = prev_i;
      csq_pkg::CELL_TAKE_NEXT: data_d = next_i;
      default:                 data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== sv/csq_stack.sv =====
`timescale 1ns / 1ps

module csq_stack #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  csq_pkg::stk_cmd_e     cmd_i,
  input  logic [DATA_WIDTH-1:0] push_data_i,
  output logic [DATA_WIDTH-1:0] top_o,
  output logic [CW-1:0]         count_o
);

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [CW-1:0]         count_q, count_d;

  // Cell zero is the top; a push moves every word one cell deeper.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    csq_pkg::cell_cmd_e    cmd;
    logic [DATA_WIDTH-1:0] prev, next;

    if (i == 0) begin : g_top
      assign prev = push_data_i;
      always_comb begin
        case (cmd_i)
          csq_pkg::STK_PUSH: cmd = csq_pkg::CELL_TAKE_PREV;
          csq_pkg::STK_REPL: cmd = csq_pkg::CELL_TAKE_PREV;
          csq_pkg::STK_POP:  cmd = csq_pkg::CELL_TAKE_NEXT;
          default:           cmd = csq_pkg::CELL_HOLD;
        endcase
      end
    end else begin : g_inner
      assign prev = cell_data[i-1];
      always_comb begin
        case (cmd_i)
          csq_pkg::STK_PUSH: cmd = csq_pkg::CELL_TAKE_PREV;
          csq_pkg::STK_POP:  cmd = csq_pkg::CELL_TAKE_NEXT;
          default:           cmd = csq_pkg::CELL_HOLD;
        endcase
      end
    end

    if (i == DEPTH - 1) begin : g_last
      assign next = cell_data[i];
    end else begin : g_mid
      assign next = cell_data[i+1];
    end

    csq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i (clk_i),
      .cmd_i (cmd),
      .prev_i(prev),
      .next_i(next),
      .data_o(cell_data[i])
    );
  end

  always_comb begin
    case (cmd_i)
      csq_pkg::STK_PUSH: count_d = count_q + CW'(1);
      csq_pkg::STK_POP:  count_d = count_q - CW'(1);
      default:           count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign top_o   = cell_data[0];
  assign count_o = count_q;

endmodule

// ===== sv/csq_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module csq_ctrl #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned CW        = $clog2(CAPACITY + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [csq_pkg::OpWidth-1:0]       op_i,
  input  logic [DATA_WIDTH-1:0]             value_i,
  input  logic [DATA_WIDTH-1:0]             left_top_i,
  input  logic [CW-1:0]                     left_count_i,
  input  logic [CW-1:0]                     right_count_i,
  output logic                              busy_o,
  output csq_pkg::zip_ctl_t                 ctl_o,
  output logic [DATA_WIDTH-1:0]             right_push_o,
  output logic                              done_o,
  output logic                              error_o
);

  csq_pkg::csq_state_e   state_q, state_d;
  logic                  pend_q, pend_d;
  logic [DATA_WIDTH-1:0] value_q, value_d;
  logic                  done_q, done_d;
  logic                  err_q, err_d;

  logic [CW-1:0] total;
  logic          full, here, left_any, last_move, accept;

  assign total     = left_count_i + right_count_i;
  assign full      = (total == CW'(CAPACITY));
  assign here      = (right_count_i != '0);
  assign left_any  = (left_count_i != '0);
  assign last_move = (left_count_i == CW'(1));
  assign accept    = start_i && (state_q == csq_pkg::ST_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      csq_pkg::ST_IDLE: begin
        if (accept) begin
          case (csq_pkg::op_e'(op_i))
            csq_pkg::OP_START: begin
              if (left_any) state_d = csq_pkg::ST_REWIND;
            end
            csq_pkg::OP_INSERT: begin
              if (!full && !here && left_any) state_d = csq_pkg::ST_REWIND;
            end
            default: state_d = csq_pkg::ST_IDLE;
          endcase
        end
      end
      csq_pkg::ST_REWIND: begin
        if (last_move) state_d = pend_q ? csq_pkg::ST_PLACE : csq_pkg::ST_IDLE;
      end
      csq_pkg::ST_PLACE: state_d = csq_pkg::ST_IDLE;
      default:           state_d = csq_pkg::ST_IDLE;
    endcase
  end

  // Stack commands and result strobe.
  always_comb begin
    ctl_o.left_cmd  = csq_pkg::STK_HOLD;
    ctl_o.right_cmd = csq_pkg::STK_HOLD;
    right_push_o    = value_i;
    done_d          = 1'b0;
    err_d           = 1'b0;
    pend_d          = pend_q;
    value_d         = value_q;
    case (state_q)
      csq_pkg::ST_IDLE: begin
        if (accept) begin
          case (csq_pkg::op_e'(op_i))
            csq_pkg::OP_START: begin
              pend_d = 1'b0;
              done_d = !left_any;
            end
            csq_pkg::OP_ADVANCE: begin
              done_d = 1'b1;
              if (!here) begin
                err_d = 1'b1;
              end else begin
                ctl_o.left_cmd  = csq_pkg::STK_PUSH;
                ctl_o.right_cmd = csq_pkg::STK_POP;
              end
            end
            csq_pkg::OP_INSERT: begin
              if (full) begin
                done_d = 1'b1;
                err_d  = 1'b1;
              end else if (here || !left_any) begin
                done_d          = 1'b1;
                ctl_o.right_cmd = csq_pkg::STK_PUSH;
              end else begin
                // No current item: rewind to the head, then place the word.
                pend_d  = 1'b1;
                value_d = value_i;
              end
            end
            csq_pkg::OP_ATTACH: begin
              done_d = 1'b1;
              if (full) begin
                err_d = 1'b1;
              end else if (here) begin
                ctl_o.left_cmd  = csq_pkg::STK_PUSH;
                ctl_o.right_cmd = csq_pkg::STK_REPL;
              end else begin
                ctl_o.right_cmd = csq_pkg::STK_PUSH;
              end
            end
            csq_pkg::OP_REMOVE: begin
              done_d = 1'b1;
              if (!here) begin
                err_d = 1'b1;
              end else begin
                ctl_o.right_cmd = csq_pkg::STK_POP;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      csq_pkg::ST_REWIND: begin
        ctl_o.left_cmd  = csq_pkg::STK_POP;
        ctl_o.right_cmd = csq_pkg::STK_PUSH;
        right_push_o    = left_top_i;
        done_d          = last_move && !pend_q;
      end
      csq_pkg::ST_PLACE: begin
        ctl_o.right_cmd = csq_pkg::STK_PUSH;
        right_push_o    = value_q;
        done_d          = 1'b1;
        pend_d          = 1'b0;
      end
      default: done_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csq_pkg::ST_IDLE;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign busy_o  = (state_q != csq_pkg::ST_IDLE);
  assign done_o  = done_q;
  assign error_o = err_q;

  `ASSERT_CLK(a_total_bound, ({1'b0, left_count_i} + {1'b0, right_count_i}) <= (CW+1)'(CAPACITY), "list holds more than capacity")
  `ASSERT_CLK(a_rewind_has_left, (state_q != csq_pkg::ST_REWIND) || left_any, "rewind with nothing ahead of the cursor")
  `ASSERT_NEXT(a_err_keeps_state, accept && err_d, $stable(left_count_i) && $stable(right_count_i) && done_o, "refused request changed the list")
  `ASSERT_NEXT(a_place_done, state_q == csq_pkg::ST_PLACE, done_o && !error_o && (state_q == csq_pkg::ST_IDLE), "placement after rewind gave no result")

endmodule

// ===== sv/cursor_sequence_table.sv =====
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY words with a cursor, built as two stacks of
// cells that meet at the cursor: the left stack holds the items ahead of the
// cursor, the right stack holds the current item on its top and the rest.
// A request (op_i, value_i) is taken at a rising edge where start is high and
// busy is low. Its result is on current_value_o, has_current_o, count_o and
// error_o for exactly one cycle, while done_o is high; the receiver cannot
// stall, so nothing is held back on the result side.
// Advance, attach, remove, read, refused requests, insert with a current item
// and insert into an empty list need no rewind: done_o rises in the cycle after
// acceptance and a new request may be taken in the same cycle as that strobe.
// Start, and insert without a current item on a list that is not empty, rewind
// the cursor to the head by moving one word per cycle from the left to the
// right stack, and insert then places its word on the right stack; busy stays
// high meanwhile.
// Reset empties the list and leaves the cursor at the head; stored words are
// not cleared.
module cursor_sequence_table #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [csq_pkg::OpWidth-1:0]          op_i,
  input  logic [csq_pkg::ValueWidth-1:0]       value_i,
  output logic                                 done_o,
  output logic [csq_pkg::ValueWidth-1:0]       current_value_o,
  output logic                                 has_current_o,
  output logic [csq_pkg::CountWidth-1:0]       count_o,
  output logic                                 error_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  csq_pkg::zip_ctl_t     ctl;
  logic [DATA_WIDTH-1:0] value_m, left_top, right_top, right_push;
  logic [CW-1:0]         left_count, right_count, total;
  logic [63:0]           value_ext, cur_ext, total_ext;

  assign value_ext = 64'(value_i);
  assign value_m   = value_ext[DATA_WIDTH-1:0];

  csq_ctrl #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .op_i         (op_i),
    .value_i      (value_m),
    .left_top_i   (left_top),
    .left_count_i (left_count),
    .right_count_i(right_count),
    .busy_o       (busy),
    .ctl_o        (ctl),
    .right_push_o (right_push),
    .done_o       (done_o),
    .error_o      (error_o)
  );

  // The left stack only ever receives the word leaving the right stack's top.
  csq_stack #(
    .DEPTH     (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (ctl.left_cmd),
    .push_data_i(right_top),
    .top_o      (left_top),
    .count_o    (left_count)
  );

  csq_stack #(
    .DEPTH     (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (ctl.right_cmd),
    .push_data_i(right_push),
    .top_o      (right_top),
    .count_o    (right_count)
  );

  assign total           = left_count + right_count;
  assign total_ext       = 64'(total);
  assign has_current_o   = (right_count != '0);
  assign cur_ext         = has_current_o ? 64'(right_top) : 64'd0;
  assign current_value_o = cur_ext[csq_pkg::ValueWidth-1:0];
  assign count_o         = total_ext[csq_pkg::CountWidth-1:0];

endmodule
